FILE: sv/logistic_map_note_sequencer_macros.svh
// Assertion macros for the checker file of the note sequencer.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef LOGISTIC_MAP_NOTE_SEQUENCER_MACROS_SVH
`define LOGISTIC_MAP_NOTE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LMNS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define LMNS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: sv/lmns_pkg.sv
// Shared types, constants and pitch tables of the note sequencer.
// No dependencies; the multiplier, sequencer, checker and bench take names from here by scope.
`timescale 1ns / 1ps
`default_nettype none

package lmns_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned PERIOD_W   = 24;
  localparam int unsigned RATE_W     = FRAC_BITS + 2;
  localparam int unsigned SCALE_W    = 2;
  localparam int unsigned ELAPSED_W  = 16;
  localparam int unsigned PITCH_W    = 6;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned NUM_SLOTS  = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = PERIOD_W;

  localparam int unsigned MUL_A_W = RATE_W;
  localparam int unsigned MUL_B_W = FRAC_BITS + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_BEAT_PERIOD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH_RATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SELECT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHAOS_SEED   = 2'd3;

  localparam logic [SCALE_W-1:0] SCALE_MAJOR      = 2'd0;
  localparam logic [SCALE_W-1:0] SCALE_LYDIAN     = 2'd1;
  localparam logic [SCALE_W-1:0] SCALE_MIXOLYDIAN = 2'd2;

  localparam logic [PERIOD_W-1:0]  BEAT_PERIOD_RST = 24'd500;
  localparam logic [RATE_W-1:0]    GROWTH_RATE_RST = 18'd242483;
  localparam logic [FRAC_BITS-1:0] CHAOS_SEED_RST  = 16'd32768;

  localparam logic [PITCH_W-1:0] PITCH_MAJOR [NUM_SLOTS] = '{
    6'd10, 6'd13, 6'd16, 6'd17, 6'd20, 6'd23, 6'd26,
    6'd27, 6'd30, 6'd33, 6'd36, 6'd39, 6'd40, 6'd40};
  localparam logic [PITCH_W-1:0] PITCH_LYDIAN [NUM_SLOTS] = '{
    6'd10, 6'd13, 6'd16, 6'd17, 6'd18, 6'd21, 6'd24,
    6'd27, 6'd30, 6'd33, 6'd36, 6'd39, 6'd40, 6'd40};
  localparam logic [PITCH_W-1:0] PITCH_MIXOLYDIAN [NUM_SLOTS] = '{
    6'd10, 6'd13, 6'd16, 6'd17, 6'd20, 6'd23, 6'd26,
    6'd27, 6'd30, 6'd33, 6'd36, 6'd37, 6'd40, 6'd40};

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed;
  } in_word_t;

  typedef struct packed {
    logic               note_on;
    logic [PITCH_W-1:0] pitch_step;
    logic [SLOT_W-1:0]  note_slot;
  } out_word_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  function automatic logic [PITCH_W-1:0] pitch_lookup(input logic [SCALE_W-1:0] scale,
                                                      input logic [SLOT_W-1:0] slot);
    logic [PITCH_W-1:0] p;
    case (scale)
      SCALE_LYDIAN:     p = PITCH_LYDIAN[slot];
      SCALE_MIXOLYDIAN: p = PITCH_MIXOLYDIAN[slot];
      default:          p = PITCH_MAJOR[slot];
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: sv/lmns_stream_if.sv
// Valid/ready stream channel carrying one word of a given payload type.
// Depends on nothing; payload types come from lmns_pkg at instantiation.
`timescale 1ns / 1ps
`default_nettype none

interface lmns_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/lmns_serial_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on lmns_pkg for operand widths and the request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module lmns_serial_mul (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  lmns_pkg::mul_req_t req_i,
  output lmns_pkg::mul_rsp_t rsp_o
);

  logic [lmns_pkg::MUL_A_W-1:0]   a_q;
  logic [lmns_pkg::PROD_W-1:0]    p_q, p_d;
  logic [lmns_pkg::MUL_CNT_W-1:0] cnt_q;
  logic                           done_q;
  logic [lmns_pkg::MUL_A_W:0]     sum;

  always_comb begin
    sum = {1'b0, p_q[lmns_pkg::PROD_W-1 -: lmns_pkg::MUL_A_W]} +
          {1'b0, (p_q[0] ? a_q : {lmns_pkg::MUL_A_W{1'b0}})};
    p_d = {sum, p_q[lmns_pkg::MUL_B_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= lmns_pkg::MUL_CNT_W'(lmns_pkg::MUL_B_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == lmns_pkg::MUL_CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      p_q <= {{lmns_pkg::MUL_A_W{1'b0}}, req_i.b};
    end else if (cnt_q != '0) begin
      p_q <= p_d;
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = p_q;

endmodule

`default_nettype wire

FILE: sv/logistic_map_note_sequencer.sv
// Logistic-map note sequencer: beat accumulator, chaos update and pitch lookup.
// Depends on lmns_pkg, lmns_stream_if and lmns_serial_mul.
//
// Usage:
//   in_i carries one elapsed-time word per handshake; out_o carries note words
//   (note_on, pitch_step, note_slot). Configuration is a plain write port:
//   cfg_we_i with cfg_idx_i 0 beat period, 1 growth rate, 2 scale select,
//   3 chaos seed (which also reloads the chaos value). Write only while idle.
// Timing:
//   A word that causes neither a note-on nor a note-off leaves the sequencer
//   idle. A note-off word goes to the result register and then to the output
//   register. A word that crosses the beat runs the logistic map through two
//   passes of one shared bit-serial multiplier before its note-on goes the
//   same way. No new input word is taken until the result has been moved into
//   the output register.
// Reset:
//   Asynchronous, active low. Clears the accumulator and sounding flag, loads
//   the chaos value with 0.5 and the registers with their defaults.
// Stall:
//   A waiting output word holds in its register; the next input word is still
//   taken and worked, and its own result waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module logistic_map_note_sequencer #(
  parameter int unsigned ACC_BITS = 24
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  lmns_stream_if.sink                          in_i,
  lmns_stream_if.source                        out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [lmns_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lmns_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned F     = lmns_pkg::FRAC_BITS;
  localparam int unsigned CMP_W = (ACC_BITS > lmns_pkg::PERIOD_W) ? ACC_BITS
                                                                  : lmns_pkg::PERIOD_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SQ   = 4'b0010,
    ST_RT   = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [lmns_pkg::PERIOD_W-1:0] period_q;
  logic [lmns_pkg::RATE_W-1:0]   rate_q;
  logic [lmns_pkg::SCALE_W-1:0]  scale_q;
  logic [F-1:0]                  chaos_q, chaos_d;
  logic [ACC_BITS-1:0]           acc_q, acc_d;
  logic                          sounding_q, sounding_d;

  lmns_pkg::out_word_t res_q, res_d;
  lmns_pkg::out_word_t out_data_q;
  logic                out_valid_q;

  lmns_pkg::mul_req_t mul_req;
  lmns_pkg::mul_rsp_t mul_rsp;

  logic                in_fire;
  logic                out_free;
  logic [ACC_BITS:0]   acc_sum;
  logic [ACC_BITS-1:0] acc_sat;
  logic                beat;
  logic [F:0]          one_minus_x;
  logic [F-1:0]        x_next;
  logic [F+3:0]        x_times14;
  logic [lmns_pkg::SLOT_W-1:0] slot;

  lmns_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_comb begin
    acc_sum     = {1'b0, acc_q} + (ACC_BITS + 1)'(in_i.data.elapsed);
    acc_sat     = acc_sum[ACC_BITS] ? {ACC_BITS{1'b1}} : acc_sum[ACC_BITS-1:0];
    beat        = CMP_W'(acc_sat) > CMP_W'(period_q);
    one_minus_x = {1'b1, {F{1'b0}}} - {1'b0, chaos_q};
    x_next      = (|mul_rsp.product[lmns_pkg::PROD_W-1:2*F]) ? {F{1'b1}}
                                                             : mul_rsp.product[2*F-1:F];
    x_times14   = {x_next, 4'b0000} - {3'b000, x_next, 1'b0};
    slot        = x_times14[F+3:F];
  end

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    chaos_d     = chaos_q;
    sounding_d  = sounding_q;
    res_d       = res_q;
    mul_req     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (beat) begin
            acc_d       = '0;
            sounding_d  = 1'b1;
            mul_req.start = 1'b1;
            mul_req.a   = lmns_pkg::MUL_A_W'(chaos_q);
            mul_req.b   = one_minus_x;
            state_d     = ST_SQ;
          end else begin
            acc_d = acc_sat;
            if (sounding_q) begin
              sounding_d = 1'b0;
              res_d      = '0;
              state_d    = ST_EMIT;
            end
          end
        end
      end
      ST_SQ: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = rate_q;
          mul_req.b     = lmns_pkg::MUL_B_W'(mul_rsp.product[2*F-1:F]);
          state_d       = ST_RT;
        end
      end
      ST_RT: begin
        if (mul_rsp.done) begin
          chaos_d          = x_next;
          res_d.note_on    = 1'b1;
          res_d.note_slot  = slot;
          res_d.pitch_step = lmns_pkg::pitch_lookup(scale_q, slot);
          state_d          = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cfg_we_i && cfg_idx_i == lmns_pkg::REG_CHAOS_SEED) begin
      chaos_d = cfg_data_i[F-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      acc_q      <= '0;
      chaos_q    <= lmns_pkg::CHAOS_SEED_RST;
      sounding_q <= 1'b0;
      period_q   <= lmns_pkg::BEAT_PERIOD_RST;
      rate_q     <= lmns_pkg::GROWTH_RATE_RST;
      scale_q    <= lmns_pkg::SCALE_MAJOR;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      acc_q      <= acc_d;
      chaos_q    <= chaos_d;
      sounding_q <= sounding_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lmns_pkg::REG_BEAT_PERIOD:  period_q <= cfg_data_i;
          lmns_pkg::REG_GROWTH_RATE:  rate_q   <= cfg_data_i[lmns_pkg::RATE_W-1:0];
          lmns_pkg::REG_SCALE_SELECT: scale_q  <= cfg_data_i[lmns_pkg::SCALE_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == ST_EMIT && out_free) begin
      out_data_q <= res_q;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lmns_checker.sv
// Port-level checker of the note sequencer output channel, bound to the top level.
// Depends on lmns_pkg and logistic_map_note_sequencer_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "logistic_map_note_sequencer_macros.svh"

module lmns_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input lmns_pkg::out_word_t      out_data_i
);

  `LMNS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `LMNS_ASSERT_NOW(a_on_pitch, out_valid_i && out_data_i.note_on, out_data_i.pitch_step >= 6'd10 && out_data_i.pitch_step <= 6'd40)
  `LMNS_ASSERT_NOW(a_on_slot, out_valid_i && out_data_i.note_on, out_data_i.note_slot <= 4'd13)
  `LMNS_ASSERT_NOW(a_off_zero, out_valid_i && !out_data_i.note_on, out_data_i.pitch_step == '0 && out_data_i.note_slot == '0)

endmodule

bind logistic_map_note_sequencer lmns_checker u_lmns_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire

FILE: verif/logistic_map_note_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking bench for logistic_map_note_sequencer: drives elapsed-time words, predicts
// note-on/off words from its own beat and chaos model. Depends on lmns_pkg and lmns_stream_if.

module logistic_map_note_sequencer_test;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam logic [lmns_pkg::PERIOD_W:0] ACC_FULL = 25'h0FFFFFF;
  localparam logic [lmns_pkg::PITCH_W-1:0] NOTE_PITCH [3][lmns_pkg::NUM_SLOTS] = '{
    '{6'd10, 6'd13, 6'd16, 6'd17, 6'd20, 6'd23, 6'd26,
      6'd27, 6'd30, 6'd33, 6'd36, 6'd39, 6'd40, 6'd40},
    '{6'd10, 6'd13, 6'd16, 6'd17, 6'd18, 6'd21, 6'd24,
      6'd27, 6'd30, 6'd33, 6'd36, 6'd39, 6'd40, 6'd40},
    '{6'd10, 6'd13, 6'd16, 6'd17, 6'd20, 6'd23, 6'd26,
      6'd27, 6'd30, 6'd33, 6'd36, 6'd37, 6'd40, 6'd40}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [lmns_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [lmns_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  lmns_stream_if #(.word_t(lmns_pkg::in_word_t))  in_if ();
  lmns_stream_if #(.word_t(lmns_pkg::out_word_t)) out_if ();

  logistic_map_note_sequencer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Model copy of registers and state.
  logic [lmns_pkg::PERIOD_W-1:0]  beat_period = lmns_pkg::BEAT_PERIOD_RST;
  logic [lmns_pkg::RATE_W-1:0]    growth_rate = lmns_pkg::GROWTH_RATE_RST;
  logic [lmns_pkg::SCALE_W-1:0]   scale_sel   = lmns_pkg::SCALE_MAJOR;
  logic [lmns_pkg::PERIOD_W-1:0]  beat_acc    = '0;
  logic [lmns_pkg::FRAC_BITS-1:0] chaos_x     = lmns_pkg::CHAOS_SEED_RST;
  logic                           sounding    = 1'b0;

  lmns_pkg::in_word_t  elapsed_q [$];
  lmns_pkg::out_word_t pending_notes [$];

  int errors = 0;
  int words_queued = 0;
  int words_taken = 0;
  int note_ons = 0;
  int note_offs = 0;
  int settings_count = 1;
  int unsigned cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int pat_count = 0;
  logic [15:0] stall_mask = 16'hFFFF;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic advance_beat(input logic [lmns_pkg::ELAPSED_W-1:0] elapsed);
    logic [lmns_pkg::PERIOD_W:0] sum;
    longint unsigned t, nx, slot;
    logic [lmns_pkg::SCALE_W-1:0] row;
    lmns_pkg::out_word_t note;
    sum = {1'b0, beat_acc} + elapsed;
    if (sum > ACC_FULL) sum = ACC_FULL;
    beat_acc = sum[lmns_pkg::PERIOD_W-1:0];
    if (sum > {1'b0, beat_period}) begin
      beat_acc = '0;
      t = (longint'(chaos_x) * (longint'(1) << lmns_pkg::FRAC_BITS)
           - longint'(chaos_x) * chaos_x) >> lmns_pkg::FRAC_BITS;
      nx = (longint'(growth_rate) * t) >> lmns_pkg::FRAC_BITS;
      if (nx > 65535) nx = 65535;
      chaos_x = nx[lmns_pkg::FRAC_BITS-1:0];
      slot = (longint'(chaos_x) * lmns_pkg::NUM_SLOTS) >> lmns_pkg::FRAC_BITS;
      if (slot >= lmns_pkg::NUM_SLOTS) slot = lmns_pkg::NUM_SLOTS - 1;
      row = (scale_sel > lmns_pkg::SCALE_MIXOLYDIAN) ? lmns_pkg::SCALE_MAJOR : scale_sel;
      note.note_on = 1'b1;
      note.pitch_step = NOTE_PITCH[row][slot];
      note.note_slot = slot[lmns_pkg::SLOT_W-1:0];
      sounding = 1'b1;
      pending_notes.push_back(note);
    end else if (sounding) begin
      sounding = 1'b0;
      note = '0;
      pending_notes.push_back(note);
    end
  endtask

  task automatic write_reg(input logic [lmns_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lmns_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    case (idx)
      lmns_pkg::REG_BEAT_PERIOD:  beat_period = value;
      lmns_pkg::REG_GROWTH_RATE:  growth_rate = value[lmns_pkg::RATE_W-1:0];
      lmns_pkg::REG_SCALE_SELECT: scale_sel = value[lmns_pkg::SCALE_W-1:0];
      lmns_pkg::REG_CHAOS_SEED:   chaos_x = value[lmns_pkg::FRAC_BITS-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_word(input logic [lmns_pkg::ELAPSED_W-1:0] elapsed);
    lmns_pkg::in_word_t w;
    w.elapsed = elapsed;
    elapsed_q.push_back(w);
    words_queued++;
  endtask

  function automatic logic [lmns_pkg::ELAPSED_W-1:0] pick_elapsed();
    longint unsigned cap;
    cap = longint'(beat_period) / 3 + 1;
    if (cap > 65535) cap = 65535;
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return lmns_pkg::ELAPSED_W'($urandom_range(0, 65535));
      3:       return '1;
      default: return lmns_pkg::ELAPSED_W'($urandom_range(0, int'(cap)));
    endcase
  endfunction

  task automatic wait_idle();
    while (words_taken != words_queued || pending_notes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        advance_beat(in_if.data.elapsed);
        words_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (elapsed_q.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.data <= elapsed_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each word, stall on a rotating mask.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_notes.size() == 0) begin
          $error("unexpected note word %p", out_if.data);
          errors++;
        end else begin
          lmns_pkg::out_word_t want;
          want = pending_notes.pop_front();
          if (out_if.data.note_on !== want.note_on) begin
            $error("note_on expected %0d got %0d", want.note_on, out_if.data.note_on);
            errors++;
          end
          if (out_if.data.pitch_step !== want.pitch_step) begin
            $error("pitch_step expected %0d got %0d", want.pitch_step, out_if.data.pitch_step);
            errors++;
          end
          if (out_if.data.note_slot !== want.note_slot) begin
            $error("note_slot expected %0d got %0d", want.note_slot, out_if.data.note_slot);
            errors++;
          end
          if (want.note_on) note_ons++;
          else note_offs++;
        end
      end
      pat_count++;
      if (pat_count % 64 == 0) begin
        stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end else begin
        stall_mask = {stall_mask[0], stall_mask[15:1]};
      end
      out_if.ready <= stall_mask[0];
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [lmns_pkg::RATE_W-1:0] r;
    logic [lmns_pkg::PERIOD_W-1:0] p;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: beat edge, note-off, note-on while sounding.
    queue_word(16'hFFFF);
    queue_word(16'd0);
    queue_word(16'd0);
    queue_word(16'd500);
    queue_word(16'd1);
    queue_word(16'd0);
    queue_word(16'd501);
    queue_word(16'hFFFF);
    queue_word(16'd0);
    queue_word(16'h5555);
    queue_word(16'hAAAA);
    queue_word(16'd250);
    queue_word(16'd250);
    queue_word(16'd1);
    wait_idle();

    // Zero period, zero seed, full rate, lydian.
    write_reg(lmns_pkg::REG_BEAT_PERIOD, 24'd0);
    write_reg(lmns_pkg::REG_GROWTH_RATE, 24'h03FFFF);
    write_reg(lmns_pkg::REG_SCALE_SELECT, 24'(lmns_pkg::SCALE_LYDIAN));
    write_reg(lmns_pkg::REG_CHAOS_SEED, 24'd0);
    settings_count++;
    queue_word(16'd0);
    queue_word(16'd1);
    queue_word(16'd1);
    queue_word(16'd0);
    queue_word(16'd0);
    queue_word(16'hFFFF);
    repeat (20) queue_word(pick_elapsed());
    wait_idle();

    // Period equal to the saturated accumulator: never fires.
    write_reg(lmns_pkg::REG_BEAT_PERIOD, 24'hFFFFFF);
    write_reg(lmns_pkg::REG_GROWTH_RATE, 24'd0);
    write_reg(lmns_pkg::REG_SCALE_SELECT, 24'd3);
    write_reg(lmns_pkg::REG_CHAOS_SEED, 24'hFFFF);
    settings_count++;
    repeat (30) queue_word(pick_elapsed());
    wait_idle();

    // One below the saturated accumulator: fires once saturation is reached.
    write_reg(lmns_pkg::REG_BEAT_PERIOD, 24'hFFFFFE);
    write_reg(lmns_pkg::REG_GROWTH_RATE, 24'd262000);
    write_reg(lmns_pkg::REG_SCALE_SELECT, 24'(lmns_pkg::SCALE_MIXOLYDIAN));
    write_reg(lmns_pkg::REG_CHAOS_SEED, 24'd1);
    settings_count++;
    repeat (258) queue_word(16'hFFFF);
    queue_word(16'd0);
    queue_word(16'd0);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 7))
        0:       p = 24'd1;
        1:       p = lmns_pkg::PERIOD_W'($urandom_range(60000, 1000000));
        default: p = lmns_pkg::PERIOD_W'($urandom_range(2, 3000));
      endcase
      r = ($urandom_range(0, 3) != 0) ? lmns_pkg::RATE_W'($urandom_range(229376, 262143))
                                      : lmns_pkg::RATE_W'($urandom_range(0, 262143));
      write_reg(lmns_pkg::REG_BEAT_PERIOD, p);
      write_reg(lmns_pkg::REG_GROWTH_RATE, {6'($urandom), r});
      write_reg(lmns_pkg::REG_SCALE_SELECT, {22'($urandom), 2'(ph % 4)});
      if ($urandom_range(0, 1) == 1)
        write_reg(lmns_pkg::REG_CHAOS_SEED, {8'($urandom), 16'($urandom_range(0, 65535))});
      settings_count++;
      repeat (130) queue_word(pick_elapsed());
      wait_idle();
    end

    $display("Ran %0d elapsed words over %0d register settings.", words_taken, settings_count);
    $display("Checked %0d note-on and %0d note-off words.", note_ons, note_offs);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
